>>> rtl/gcbs_pkg.sv
// Shared types and constants of the grid cell box sum block.
`default_nettype none

package gcbs_pkg;

  // Fixed coordinate width of the pixel position counters.
  localparam int COORD_BITS    = 12;
  // Largest usable cell side in pixels.
  localparam int MAX_CELL_SIZE = 64;
  localparam int CS_W          = 7;
  localparam int SUM_W         = 20;
  localparam int QUOT_W        = 13;
  localparam int DIV_STEPS     = 13;
  localparam int FIFO_DEPTH    = 4;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_IMAGE_WIDTH   = 3'd0,
    CFG_REGION_LEFT   = 3'd1,
    CFG_REGION_TOP    = 3'd2,
    CFG_REGION_RIGHT  = 3'd3,
    CFG_REGION_BOTTOM = 3'd4,
    CFG_CELL_SIZE     = 3'd5
  } cfg_reg_t;

  localparam logic [12:0]     IMAGE_WIDTH_RST   = 13'd720;
  localparam logic [11:0]     REGION_LEFT_RST   = 12'd200;
  localparam logic [11:0]     REGION_TOP_RST    = 12'd20;
  localparam logic [12:0]     REGION_RIGHT_RST  = 13'd700;
  localparam logic [12:0]     REGION_BOTTOM_RST = 13'd520;
  localparam logic [CS_W-1:0] CELL_SIZE_RST     = 7'd20;

  // One pixel that falls inside a counting cell, on its way to the accumulators.
  typedef struct packed {
    logic                  valid;
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] row;
    logic [7:0]            pixel;
    logic                  first;
    logic                  fin;
    logic                  last;
  } acc_req_t;

  // One finished cell.
  typedef struct packed {
    logic [SUM_W-1:0]      sum;
    logic [4:0]            column;
    logic [COORD_BITS-1:0] row;
    logic                  last;
  } cell_res_t;

endpackage

`default_nettype wire

>>> rtl/gcbs_pix_if.sv
// Pixel stream channel: valid, ready and one pixel beat.
`default_nettype none

interface gcbs_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;
  logic       frame_start;

  modport source (output valid, pixel, frame_start, input ready);
  modport sink   (input valid, pixel, frame_start, output ready);
endinterface

`default_nettype wire

>>> rtl/gcbs_cell_if.sv
// Cell result channel: valid, ready and one cell sum beat.
`default_nettype none

interface gcbs_cell_if;
  logic        valid;
  logic        ready;
  logic [19:0] cell_sum;
  logic [4:0]  cell_column;
  logic [11:0] cell_row;
  logic        last_cell;

  modport source (output valid, cell_sum, cell_column, cell_row, last_cell, input ready);
  modport sink   (input valid, cell_sum, cell_column, cell_row, last_cell, output ready);
endinterface

`default_nettype wire

>>> rtl/gcbs_div.sv
// Restoring divider, one quotient bit per cycle, used for grid geometry.
`default_nettype none

module gcbs_div import gcbs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [QUOT_W-1:0] dividend,
  input  logic [CS_W-1:0]   divisor,
  output logic              done,
  output logic [QUOT_W-1:0] quotient,
  output logic [CS_W-1:0]   remainder
);

  logic              busy;
  logic [3:0]        cnt;
  logic [QUOT_W-1:0] q;
  logic [CS_W-1:0]   r;
  logic [CS_W:0]     r_ext;
  logic              ge;

  assign r_ext = {r, q[QUOT_W-1]};
  assign ge    = r_ext >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 4'(DIV_STEPS);
      q    <= dividend;
      r    <= '0;
    end else if (busy) begin
      if (cnt != '0) begin
        cnt <= cnt - 4'd1;
        q   <= {q[QUOT_W-2:0], ge};
        r   <= ge ? CS_W'(r_ext - {1'b0, divisor}) : r_ext[CS_W-1:0];
      end else begin
        busy <= 1'b0;
      end
    end
  end

  assign done      = busy && (cnt == '0);
  assign quotient  = q;
  assign remainder = r;

endmodule

`default_nettype wire

>>> rtl/gcbs_acc.sv
// Per-column accumulator memory with read-modify-write and write forwarding.
`default_nettype none

module gcbs_acc import gcbs_pkg::*; #(
  parameter int DEPTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  acc_req_t  req,
  output logic      res_valid,
  output cell_res_t res,
  output logic      pending
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [SUM_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vbits;
  logic [SUM_W-1:0] rdata;
  acc_req_t         s1;
  logic             pw_valid;
  logic [AW-1:0]    pw_addr;
  logic [SUM_W-1:0] pw_data;
  logic [AW-1:0]    raddr;
  logic [AW-1:0]    waddr;
  logic [SUM_W-1:0] base;
  logic [SUM_W-1:0] acc;
  logic             wr;

  assign raddr = req.col[AW-1:0];
  assign waddr = s1.col[AW-1:0];
  assign wr    = s1.valid;

  // The entry written in the previous cycle is newer than what the memory returned.
  always_comb begin
    if (s1.first) begin
      base = '0;
    end else if (pw_valid && (pw_addr == waddr)) begin
      base = pw_data;
    end else if (vbits[waddr]) begin
      base = rdata;
    end else begin
      base = '0;
    end
    acc = base + SUM_W'(s1.pixel);
  end

  always_ff @(posedge clk) begin
    if (req.valid) begin
      rdata <= mem[raddr];
    end
    if (wr) begin
      mem[waddr] <= acc;
    end
  end

  always_ff @(posedge clk) begin
    s1      <= req;
    pw_addr <= waddr;
    pw_data <= acc;
    if (rst) begin
      s1.valid <= 1'b0;
      pw_valid <= 1'b0;
      vbits    <= '0;
    end else begin
      pw_valid <= wr;
      if (wr) begin
        vbits[waddr] <= 1'b1;
      end
    end
  end

  assign res_valid  = s1.valid && s1.fin;
  assign pending    = res_valid;
  assign res.sum    = acc;
  assign res.column = s1.col[4:0];
  assign res.row    = s1.row;
  assign res.last   = s1.last;

endmodule

`default_nettype wire

>>> rtl/gcbs_fifo.sv
// Small result queue that drives the cell result channel.
`default_nettype none

module gcbs_fifo import gcbs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  cell_res_t  din,
  gcbs_cell_if.source cells,
  output logic [2:0] count
);

  localparam int PW = $clog2(FIFO_DEPTH);

  cell_res_t       slots [FIFO_DEPTH];
  logic [PW-1:0]   wp;
  logic [PW-1:0]   rp;
  logic            pop;
  cell_res_t       head;

  assign pop  = cells.valid && cells.ready;
  assign head = slots[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= din;
    end
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= wp + PW'(1);
      end
      if (pop) begin
        rp <= rp + PW'(1);
      end
      count <= count + 3'(push) - 3'(pop);
    end
  end

  assign cells.valid       = count != '0;
  assign cells.cell_sum    = head.sum;
  assign cells.cell_column = head.column;
  assign cells.cell_row    = head.row;
  assign cells.last_cell   = head.last;

endmodule

`default_nettype wire

>>> rtl/grid_cell_box_sum_core.sv
// Top level of the grid cell box sum block: position tracking, geometry and control.
`default_nettype none

// The block takes 8-bit grayscale pixels in raster order, one per beat, and
// sums them over the square cells of a grid laid on the region of interest,
// starting at its top-left corner; only whole cells inside the region count,
// and at most MAX_CELLS_ACROSS columns of cells are kept. When the
// bottom-right pixel of a cell arrives, one result beat carries the cell sum,
// its grid column and row, and a flag on the last cell of the region.
// Pixels are taken at one per clock for as long as the result side keeps up;
// a result is registered and then enters a four-deep output queue, and
// outside the geometry work ready drops only while that queue, together
// with a result still in flight, is full. The grid geometry (cells across
// and down, and the cell position of the current pixel) is worked out by
// one shared divider that yields a quotient bit per cycle, in four
// divisions. It runs after reset and after every configuration write, and
// meanwhile no pixel is accepted; configuration writes are taken at any time.
// Running sums live in a memory with one entry per cell column, read when a
// pixel is accepted and written back the next cycle, with the previous write
// forwarded when two pixels in a row hit the same column. A frame_start beat
// restarts the position at the top-left pixel at once.

module grid_cell_box_sum_core import gcbs_pkg::*; #(
  parameter int MAX_CELLS_ACROSS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data,
  gcbs_pix_if.sink    pixels,
  gcbs_cell_if.source cells
);

  localparam int NCX_W = $clog2(MAX_CELLS_ACROSS + 1);

  typedef enum logic [1:0] {
    S_START,
    S_WAIT,
    S_READY
  } seq_t;

  typedef enum logic [1:0] {
    JOB_NCX,
    JOB_NCY,
    JOB_POS_X,
    JOB_POS_Y
  } job_t;

  // Configuration registers.
  logic [12:0]     img_w;
  logic [11:0]     r_left;
  logic [11:0]     r_top;
  logic [12:0]     r_right;
  logic [12:0]     r_bottom;
  logic [CS_W-1:0] cs;

  // Position of the next pixel, and its place in the cell grid.
  logic [COORD_BITS-1:0] px;
  logic [COORD_BITS-1:0] py;
  logic [CS_W-1:0]       ox;
  logic [CS_W-1:0]       oy;
  logic [COORD_BITS-1:0] cx;
  logic [COORD_BITS-1:0] cy;

  // Whole cells across (clamped) and down the region.
  logic [NCX_W-1:0] ncx;
  logic [12:0]      ncy;

  seq_t state;
  job_t job;

  // Divider hookup.
  logic              div_start;
  logic [QUOT_W-1:0] div_dividend;
  logic              div_done;
  logic [QUOT_W-1:0] div_q;
  logic [CS_W-1:0]   div_r;

  // Pixel stage.
  logic                  accept;
  logic                  fs;
  logic [COORD_BITS-1:0] ex;
  logic [COORD_BITS-1:0] ey;
  logic [CS_W-1:0]       eox;
  logic [CS_W-1:0]       eoy;
  logic [COORD_BITS-1:0] ecx;
  logic [COORD_BITS-1:0] ecy;
  logic                  cs_ok;
  logic [CS_W-1:0]       cs_m1;
  logic                  x_in;
  logic                  y_in;
  logic [12:0]           nx;
  logic [COORD_BITS-1:0] ny;
  logic                  wrap;
  logic [COORD_BITS-1:0] px_next;
  logic [COORD_BITS-1:0] py_next;
  logic [CS_W-1:0]       ox_next;
  logic [CS_W-1:0]       oy_next;
  logic [COORD_BITS-1:0] cx_next;
  logic [COORD_BITS-1:0] cy_next;
  acc_req_t              req;

  // Accumulator and queue.
  logic      res_valid;
  cell_res_t res;
  logic      pending;
  logic [2:0] fifo_count;

  function automatic logic [12:0] sat_diff(input logic [12:0] a, input logic [12:0] b);
    sat_diff = (a > b) ? a - b : 13'd0;
  endfunction

  assign pixels.ready = (state == S_READY) && ((fifo_count + 3'(pending)) <= 3'd3);
  assign accept       = pixels.valid && pixels.ready;
  assign fs           = pixels.frame_start;

  // A frame start puts this pixel at the top-left corner of the raster.
  always_comb begin
    ex    = fs ? '0 : px;
    ey    = fs ? '0 : py;
    eox   = fs ? '0 : ox;
    eoy   = fs ? '0 : oy;
    ecx   = fs ? '0 : cx;
    ecy   = fs ? '0 : cy;
    cs_ok = (cs != '0) && (cs <= CS_W'(MAX_CELL_SIZE));
    cs_m1 = cs - 7'd1;
    x_in  = ex >= r_left;
    y_in  = ey >= r_top;

    req.valid = accept && cs_ok && x_in && y_in &&
                ({1'b0, ecx} < 13'(ncx)) && ({1'b0, ecy} < ncy);
    req.col   = ecx;
    req.row   = ecy;
    req.pixel = pixels.pixel;
    req.first = (eox == '0) && (eoy == '0);
    req.fin   = (eox == cs_m1) && (eoy == cs_m1);
    req.last  = (({1'b0, ecx} + 13'd1) == 13'(ncx)) && (({1'b0, ecy} + 13'd1) == ncy);

    // The column wraps at the image width or at the end of the coordinate range.
    nx   = {1'b0, ex} + 13'd1;
    ny   = ey + 12'd1;
    wrap = (nx >= img_w) || nx[12];

    if (wrap) begin
      px_next = '0;
      ox_next = '0;
      cx_next = '0;
      py_next = ny;
      if ((ny == r_top) || (ny == '0)) begin
        oy_next = '0;
        cy_next = '0;
      end else if (y_in) begin
        if (eoy == cs_m1) begin
          oy_next = '0;
          cy_next = ecy + 12'd1;
        end else begin
          oy_next = eoy + 7'd1;
          cy_next = ecy;
        end
      end else begin
        oy_next = eoy;
        cy_next = ecy;
      end
    end else begin
      px_next = nx[11:0];
      py_next = ey;
      oy_next = eoy;
      cy_next = ecy;
      if (nx[11:0] == r_left) begin
        ox_next = '0;
        cx_next = '0;
      end else if (x_in) begin
        if (eox == cs_m1) begin
          ox_next = '0;
          cx_next = ecx + 12'd1;
        end else begin
          ox_next = eox + 7'd1;
          cx_next = ecx;
        end
      end else begin
        ox_next = eox;
        cx_next = ecx;
      end
    end
  end

  // Each geometry job is one division by the cell size.
  always_comb begin
    unique case (job)
      JOB_NCX:   div_dividend = sat_diff(r_right, {1'b0, r_left});
      JOB_NCY:   div_dividend = sat_diff(r_bottom, {1'b0, r_top});
      JOB_POS_X: div_dividend = sat_diff({1'b0, px}, {1'b0, r_left});
      JOB_POS_Y: div_dividend = sat_diff({1'b0, py}, {1'b0, r_top});
    endcase
  end

  assign div_start = state == S_START;

  always_ff @(posedge clk) begin
    if (rst) begin
      img_w    <= IMAGE_WIDTH_RST;
      r_left   <= REGION_LEFT_RST;
      r_top    <= REGION_TOP_RST;
      r_right  <= REGION_RIGHT_RST;
      r_bottom <= REGION_BOTTOM_RST;
      cs       <= CELL_SIZE_RST;
      px       <= '0;
      py       <= '0;
      ox       <= '0;
      oy       <= '0;
      cx       <= '0;
      cy       <= '0;
      state    <= S_START;
      job      <= JOB_NCX;
    end else begin
      if (accept) begin
        px <= px_next;
        py <= py_next;
        ox <= ox_next;
        oy <= oy_next;
        cx <= cx_next;
        cy <= cy_next;
      end

      if (cfg_write) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_IMAGE_WIDTH:   img_w    <= cfg_data;
          CFG_REGION_LEFT:   r_left   <= cfg_data[11:0];
          CFG_REGION_TOP:    r_top    <= cfg_data[11:0];
          CFG_REGION_RIGHT:  r_right  <= cfg_data;
          CFG_REGION_BOTTOM: r_bottom <= cfg_data;
          CFG_CELL_SIZE:     cs       <= cfg_data[CS_W-1:0];
          default: ;
        endcase
        // Any write invalidates the geometry, so it is worked out again.
        state <= S_START;
        job   <= JOB_NCX;
      end else begin
        unique case (state)
          S_START: begin
            state <= S_WAIT;
          end
          S_WAIT: begin
            if (div_done) begin
              unique case (job)
                JOB_NCX: begin
                  ncx   <= (div_q > 13'(MAX_CELLS_ACROSS)) ?
                           NCX_W'(MAX_CELLS_ACROSS) : NCX_W'(div_q);
                  job   <= JOB_NCY;
                  state <= S_START;
                end
                JOB_NCY: begin
                  ncy   <= div_q;
                  job   <= JOB_POS_X;
                  state <= S_START;
                end
                JOB_POS_X: begin
                  cx    <= div_q[COORD_BITS-1:0];
                  ox    <= div_r;
                  job   <= JOB_POS_Y;
                  state <= S_START;
                end
                JOB_POS_Y: begin
                  cy    <= div_q[COORD_BITS-1:0];
                  oy    <= div_r;
                  state <= S_READY;
                end
              endcase
            end
          end
          S_READY: ;
          default: state <= S_START;
        endcase
      end
    end
  end

  gcbs_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (cs),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  gcbs_acc #(
    .DEPTH (MAX_CELLS_ACROSS)
  ) u_acc (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .res_valid (res_valid),
    .res       (res),
    .pending   (pending)
  );

  gcbs_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (res_valid),
    .din   (res),
    .cells (cells),
    .count (fifo_count)
  );

endmodule

`default_nettype wire

>>> dv/grid_cell_box_sum_core_tb.sv
// Self-checking testbench of the grid cell box sum core: pixel frames over many grid shapes.
`timescale 1ns / 100ps

module grid_cell_box_sum_core_tb;
  import gcbs_pkg::*;

  // The block is built with its usual number of cell columns.
  localparam int CELLS_ACROSS = 32;
  // A pixel turns into a result through a registered stage, plus the output
  // queue, so this many quiet cycles are enough for anything still in flight.
  localparam int SETTLE_CYCLES = 16;
  localparam int LONG_HOLD_CYCLES = 300;
  // The random part stops once this many beats have landed in counting cells.
  localparam int RANDOM_BEATS = 1100;
  // From this point on neither side idles any more.
  localparam int CALM_BEATS = 900;
  localparam int MAX_REPORTS = 10;
  localparam int unsigned COORD_LIMIT = 1 << COORD_BITS;

  typedef struct packed {
    logic [7:0] pixel;
    logic       frame_start;
  } pix_beat_t;

  typedef enum int {FILL_RANDOM, FILL_BRIGHT} fill_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [12:0] cfg_data;

  gcbs_pix_if  pix_bus();
  gcbs_cell_if cell_bus();

  grid_cell_box_sum_core #(
    .MAX_CELLS_ACROSS(CELLS_ACROSS)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixels    (pix_bus),
    .cells     (cell_bus)
  );

  always #4 clk = ~clk;

  // Our own copy of the grid registers, kept at the register widths so that
  // writes truncate exactly as the hardware does.
  logic [12:0] grid_width;
  logic [11:0] grid_left;
  logic [11:0] grid_top;
  logic [12:0] grid_right;
  logic [12:0] grid_bottom;
  logic [6:0]  grid_cell;

  // Raster position of the next pixel and the running sum of each cell column.
  int unsigned      next_col;
  int unsigned      next_row;
  logic [SUM_W-1:0] column_sums [CELLS_ACROSS];
  int unsigned      in_cell_beats = 0;

  pix_beat_t pending_pixels [$];
  cell_res_t expected_cells [$];

  int          fail_count = 0;
  int          src_idle_pct;
  int          sink_idle_pct;
  int unsigned src_gap;
  int unsigned sink_gap;
  int unsigned hold_left;
  logic        hold_req = 1'b0;
  logic        hold_ack;

  // Works out what one accepted pixel beat does to the grid: it may restart
  // the raster position, add into the running sum of its cell column, and
  // finish a cell when it is the bottom-right pixel of that cell.
  function automatic void accumulate_pixel(pix_beat_t beat);
    int unsigned x, y, cs, ncx, ncy, cx, cy, ox, oy;
    logic [SUM_W-1:0] acc;
    cell_res_t done;
    if (beat.frame_start) begin
      next_col = 0;
      next_row = 0;
    end
    x = next_col;
    y = next_row;
    cs = grid_cell;
    // A cell size of zero or past the largest supported size yields no cells.
    if (cs >= 1 && cs <= MAX_CELL_SIZE && x >= grid_left && y >= grid_top) begin
      // Only whole cells count; an inverted or too small region has none.
      ncx = (grid_right > grid_left) ? (grid_right - grid_left) / cs : 0;
      ncy = (grid_bottom > grid_top) ? (grid_bottom - grid_top) / cs : 0;
      // Cell columns past the hardware limit are dropped, and the last cell
      // flag moves to the last column that is kept.
      if (ncx > CELLS_ACROSS) ncx = CELLS_ACROSS;
      cx = (x - grid_left) / cs;
      ox = (x - grid_left) % cs;
      cy = (y - grid_top) / cs;
      oy = (y - grid_top) % cs;
      if (cx < ncx && cy < ncy) begin
        in_cell_beats++;
        // The top-left pixel restarts the column sum, which also throws away
        // a cell left half summed by a frame start in mid-frame.
        if (ox == 0 && oy == 0) acc = SUM_W'(beat.pixel);
        else acc = column_sums[cx] + beat.pixel;
        column_sums[cx] = acc;
        if (ox == cs - 1 && oy == cs - 1) begin
          done.sum = acc;
          done.column = cx[4:0];
          done.row = cy[11:0];
          done.last = (cx == ncx - 1 && cy == ncy - 1);
          expected_cells.push_back(done);
        end
      end
    end
    // The line wraps after image_width pixels (a width of zero acts like one)
    // or at the coordinate limit; the row counter wraps at the same limit.
    x = x + 1;
    if (x >= grid_width || x >= COORD_LIMIT) begin
      next_col = 0;
      next_row = (y + 1) % COORD_LIMIT;
    end else begin
      next_col = x;
    end
  endfunction

  function automatic logic [7:0] rand_pixel();
    case ($urandom_range(9, 0))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(255, 0));
    endcase
  endfunction

  // Pixel driver. A beat offered on the bus stays until it is taken; after
  // each beat the sender may go quiet for a short burst of cycles.
  always @(posedge clk) begin : pixel_driver
    pix_beat_t beat;
    if (rst) begin
      pix_bus.valid <= 1'b0;
      src_gap <= 0;
    end else begin
      if (pix_bus.valid && pix_bus.ready)
        accumulate_pixel('{pixel: pix_bus.pixel, frame_start: pix_bus.frame_start});
      if (!pix_bus.valid || pix_bus.ready) begin
        if (src_gap != 0) begin
          pix_bus.valid <= 1'b0;
          src_gap <= src_gap - 1;
        end else if (pending_pixels.size() != 0) begin
          beat = pending_pixels.pop_front();
          pix_bus.valid <= 1'b1;
          pix_bus.pixel <= beat.pixel;
          pix_bus.frame_start <= beat.frame_start;
          if ($urandom_range(99, 0) < src_idle_pct) src_gap <= $urandom_range(8, 1);
        end else begin
          pix_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Cell monitor. Every accepted result beat is held against the oldest
  // expected cell; ready drops during idle bursts and during the long hold.
  always @(posedge clk) begin : cell_monitor
    cell_res_t want;
    if (rst) begin
      cell_bus.ready <= 1'b0;
      sink_gap <= 0;
    end else begin
      if (cell_bus.valid && cell_bus.ready) begin
        if (expected_cells.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("unexpected cell beat: sum %0d column %0d row %0d last %0b",
                     cell_bus.cell_sum, cell_bus.cell_column, cell_bus.cell_row,
                     cell_bus.last_cell);
        end else begin
          want = expected_cells.pop_front();
          if (cell_bus.cell_sum !== want.sum || cell_bus.cell_column !== want.column ||
              cell_bus.cell_row !== want.row || cell_bus.last_cell !== want.last) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("cell mismatch: expected sum %0d col %0d row %0d last %0b, got %0d %0d %0d %0b",
                       want.sum, want.column, want.row, want.last, cell_bus.cell_sum,
                       cell_bus.cell_column, cell_bus.cell_row, cell_bus.last_cell);
          end
        end
      end
      if (hold_left != 0) begin
        cell_bus.ready <= 1'b0;
      end else if (sink_gap != 0) begin
        cell_bus.ready <= 1'b0;
        sink_gap <= sink_gap - 1;
      end else begin
        cell_bus.ready <= 1'b1;
        if ($urandom_range(99, 0) < sink_idle_pct) sink_gap <= $urandom_range(8, 1);
      end
    end
  end

  // Long receiver hold-off: each toggle of hold_req keeps ready low for a
  // fixed stretch, long enough for the output queue to fill and the block to
  // push back on its pixel input.
  always @(posedge clk) begin
    if (rst) begin
      hold_ack <= 1'b0;
      hold_left <= 0;
    end else if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= LONG_HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Waits until every queued pixel has been taken and every expected cell has
  // come back, then lets the pipeline drain of pixels that give no result.
  // Sampling at the falling edge keeps this clear of the driver's updates.
  task automatic wait_quiet();
    do @(negedge clk);
    while (pending_pixels.size() != 0 || pix_bus.valid || expected_cells.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, int unsigned value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[12:0];
    case (idx)
      CFG_IMAGE_WIDTH:   grid_width = value[12:0];
      CFG_REGION_LEFT:   grid_left = value[11:0];
      CFG_REGION_TOP:    grid_top = value[11:0];
      CFG_REGION_RIGHT:  grid_right = value[12:0];
      CFG_REGION_BOTTOM: grid_bottom = value[12:0];
      CFG_CELL_SIZE:     grid_cell = value[6:0];
      default: ;
    endcase
  endtask

  // Registers change only while the block is idle, so the copy above always
  // matches the geometry the accepted pixels were summed under.
  task automatic set_grid(int unsigned w, int unsigned l, int unsigned t,
                          int unsigned r, int unsigned b, int unsigned cs);
    wait_quiet();
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_REGION_LEFT, l);
    write_reg(CFG_REGION_TOP, t);
    write_reg(CFG_REGION_RIGHT, r);
    write_reg(CFG_REGION_BOTTOM, b);
    write_reg(CFG_CELL_SIZE, cs);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // A frame is a run of pixels whose first beat carries the frame start.
  task automatic queue_frame(int unsigned beats, fill_t fill);
    for (int unsigned i = 0; i < beats; i++)
      pending_pixels.push_back('{pixel: (fill == FILL_BRIGHT) ? 8'd255 : rand_pixel(),
                                 frame_start: (i == 0)});
  endtask

  initial begin
    int unsigned w, w_eff, l, r, t, b, cs, rows, random_start;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = 3'd0;
    cfg_data = 13'd0;
    pix_bus.valid = 1'b0;
    pix_bus.pixel = 8'd0;
    pix_bus.frame_start = 1'b0;
    cell_bus.ready = 1'b0;
    grid_width = IMAGE_WIDTH_RST;
    grid_left = REGION_LEFT_RST;
    grid_top = REGION_TOP_RST;
    grid_right = REGION_RIGHT_RST;
    grid_bottom = REGION_BOTTOM_RST;
    grid_cell = CELL_SIZE_RST;
    next_col = 0;
    next_row = 0;
    foreach (column_sums[i]) column_sums[i] = '0;
    src_idle_pct = 20;
    sink_idle_pct = 20;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Under the reset geometry the first cell is far away: a few pixels must
    // leave the block silent.
    pending_pixels.push_back('{8'd77, 1'b1});
    pending_pixels.push_back('{8'd255, 1'b0});
    pending_pixels.push_back('{8'd0, 1'b0});

    // One-pixel cells: every pixel is a result, so the pixel extremes show
    // up directly in the sums, and the last one closes the region.
    set_grid(4, 0, 0, 4, 2, 1);
    pending_pixels.push_back('{8'd0, 1'b1});
    pending_pixels.push_back('{8'd255, 1'b0});
    pending_pixels.push_back('{8'd1, 1'b0});
    pending_pixels.push_back('{8'd128, 1'b0});
    pending_pixels.push_back('{8'd255, 1'b0});
    pending_pixels.push_back('{8'd0, 1'b0});
    pending_pixels.push_back('{8'd254, 1'b0});
    pending_pixels.push_back('{8'd127, 1'b0});

    // Cell size of zero, and the largest value the register holds: no cells.
    set_grid(4, 0, 0, 4, 2, 0);
    queue_frame(3, FILL_RANDOM);
    set_grid(4, 0, 0, 4, 2, 127);
    queue_frame(3, FILL_RANDOM);

    // Image width of zero behaves like one pixel per line.
    set_grid(0, 0, 0, 1, 3, 1);
    queue_frame(4, FILL_RANDOM);

    // Region with its right bound on its left bound is empty.
    set_grid(4, 3, 0, 3, 2, 1);
    queue_frame(4, FILL_RANDOM);

    // Forty one-pixel cells across: only the first thirty-two columns count.
    set_grid(40, 0, 0, 40, 2, 1);
    queue_frame(80, FILL_RANDOM);

    // Largest cell filled with full-scale pixels gives the largest sum.
    set_grid(64, 0, 0, 64, 64, 64);
    queue_frame(4096, FILL_BRIGHT);

    // Widest line with the region at its rightmost column.
    set_grid(4096, 4095, 0, 4096, 1, 1);
    queue_frame(4099, FILL_RANDOM);

    // One pixel per line: the row counter runs to its top and wraps to zero.
    set_grid(1, 0, 4095, 1, 4096, 1);
    queue_frame(4100, FILL_RANDOM);

    // Result on every pixel while the receiver holds off for a long stretch;
    // the sender keeps offering, so the block has to stall its input.
    set_grid(6, 0, 0, 6, 12, 1);
    src_idle_pct = 0;
    sink_idle_pct = 20;
    @(posedge clk);
    hold_req <= ~hold_req;
    queue_frame(72, FILL_RANDOM);

    // Random geometries, mostly small so frames stay short. Most frames are
    // whole; some are cut short by an early frame start, and some are
    // followed by stray pixels with random frame start bits.
    random_start = in_cell_beats;
    while (in_cell_beats - random_start < RANDOM_BEATS) begin
      w = ($urandom_range(15, 0) == 0) ? 0 : $urandom_range(48, 1);
      w_eff = (w == 0) ? 1 : w;
      l = $urandom_range(w_eff / 2, 0);
      if ($urandom_range(7, 0) == 0) r = $urandom_range(l, 0);
      else r = $urandom_range(w_eff, l + 1);
      t = $urandom_range(3, 0);
      b = t + $urandom_range(12, 0);
      case ($urandom_range(9, 0))
        0: cs = 0;
        1: cs = $urandom_range(127, 65);
        2: cs = $urandom_range(16, 7);
        default: cs = $urandom_range(6, 1);
      endcase
      rows = b + $urandom_range(2, 0);
      if (rows * w_eff > 400) rows = 400 / w_eff;
      if (rows == 0) rows = 1;
      set_grid(w, l, t, r, b, cs);
      if (in_cell_beats - random_start >= CALM_BEATS) begin
        src_idle_pct = 0;
        sink_idle_pct = 0;
      end else begin
        src_idle_pct = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(40, 5);
        sink_idle_pct = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(40, 5);
      end
      repeat ($urandom_range(2, 1)) begin
        if ($urandom_range(5, 0) == 0)
          queue_frame($urandom_range(rows * w_eff - 1, 1), FILL_RANDOM);
        queue_frame(rows * w_eff, FILL_RANDOM);
        if ($urandom_range(7, 0) == 0)
          repeat ($urandom_range(10, 1))
            pending_pixels.push_back('{rand_pixel(), $urandom_range(3, 0) == 0});
      end
    end

    src_idle_pct = 0;
    sink_idle_pct = 0;
    wait_quiet();
    if (fail_count == 0 && expected_cells.size() == 0) begin
      $display("[grid_cell_box_sum_core] OK");
    end else begin
      $display("[grid_cell_box_sum_core] ERROR");
    end
    $finish;
  end

  // Guard against a hung handshake: far beyond the slowest correct run.
  initial begin
    #8000000;
    $display("[grid_cell_box_sum_core] ERROR");
    $finish;
  end

endmodule
